@@ src/tmdg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt mouse delta generator package
// Shared types, register indexes, reset values and the circle step table.
// ----------------------------------------------------------------------------
package tmdg_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 15;
	localparam int unsigned IN_DATA_W   = 40;
	localparam int unsigned OUT_DATA_W  = 16;
	localparam int unsigned CIRCLE_LEN  = 12;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_LOW       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_MID       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_HIGH      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FAILURE_LIMIT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_REPORTS   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd35;
	localparam logic [14:0] RST_TILT_LOW       = 15'd4500;
	localparam logic [14:0] RST_TILT_MID       = 15'd9500;
	localparam logic [14:0] RST_TILT_HIGH      = 15'd14000;
	localparam logic [3:0]  RST_FAILURE_LIMIT  = 4'd3;
	localparam logic [7:0]  RST_HOLD_REPORTS   = 8'd8;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_REPORT = 2'd1,
		MODE_SETUP  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [14:0] tilt_low;
		logic [14:0] tilt_mid;
		logic [14:0] tilt_high;
		logic [3:0]  failure_limit;
		logic [7:0]  hold_reports;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic               button_pressed;
		logic               host_ready;
		logic               read_ok;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic               setup_ok;
	} item_t;

	typedef struct packed {
		logic              report_valid;
		logic signed [4:0] delta_x;
		logic signed [4:0] delta_y;
		logic              auto_mode;
		logic              sensor_ready;
	} result_t;

	typedef struct packed {
		logic signed [4:0] dx;
		logic signed [4:0] dy;
	} delta_t;

	// One step of the circle traced in automatic mode.
	function automatic delta_t circle_step_delta(input logic [3:0] step);
		delta_t d;
		unique case (step)
			4'd0:    d = '{dx: 5'sd2,  dy: 5'sd0};
			4'd1:    d = '{dx: 5'sd2,  dy: 5'sd1};
			4'd2:    d = '{dx: 5'sd1,  dy: 5'sd2};
			4'd3:    d = '{dx: 5'sd0,  dy: 5'sd2};
			4'd4:    d = '{dx: -5'sd1, dy: 5'sd2};
			4'd5:    d = '{dx: -5'sd2, dy: 5'sd1};
			4'd6:    d = '{dx: -5'sd2, dy: 5'sd0};
			4'd7:    d = '{dx: -5'sd2, dy: -5'sd1};
			4'd8:    d = '{dx: -5'sd1, dy: -5'sd2};
			4'd9:    d = '{dx: 5'sd0,  dy: -5'sd2};
			4'd10:   d = '{dx: 5'sd1,  dy: -5'sd2};
			4'd11:   d = '{dx: 5'sd2,  dy: -5'sd1};
			default: d = '{dx: 5'sd2,  dy: 5'sd0};
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

@@ src/tilt_mouse_delta_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt mouse delta generator
// Turns accelerometer tilt, button ticks and sensor setup results into mouse
// movement reports, with a debounced button that toggles a circle mode.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel: tuser selects a millisecond tick, a
//   report slot or a sensor setup result, and tdata carries the button level,
//   host and read flags, both acceleration samples and the setup flag.
//   Every input transfer yields exactly one result transfer on m_axis, in
//   order. A result carries report_valid, the two deltas, the automatic mode
//   flag (the LED) and the sensor ready flag as they stand after the item.
//   The result appears on m_axis once it has passed the input register and
//   then the output register; throughput is one item per cycle while the
//   receiver takes results. The item is held in an input register, the state
//   update and the result are formed in one pass of short logic, and the
//   result lands in an output register.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more item, after which s_axis_tready drops
//   until the result is taken.
//   Reset clears all state and both pipeline registers and loads the
//   default register values. Configuration writes take effect at the next
//   edge on cfg_wen; the user makes them only while idle; the block trusts this.
// ----------------------------------------------------------------------------
module tilt_mouse_delta_generator_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port.
	input  wire logic                                 cfg_wen,
	input  wire logic [tmdg_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [tmdg_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input stream.
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// From bit 0: button_pressed, host_ready, read_ok, accel_x[15:0],
	// accel_y[15:0], setup_ok, then zero padding.
	input  wire logic [tmdg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// From bit 0: mode[1:0].
	input  wire logic [1:0]                           s_axis_tuser,
	// Output stream.
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// From bit 0: report_valid, delta_x[4:0], delta_y[4:0], auto_mode,
	// sensor_ready, then zero padding.
	output logic [tmdg_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

	tmdg_pkg::cfg_t    cfg;
	tmdg_pkg::item_t   item_s1;
	tmdg_pkg::result_t result_next;
	tmdg_pkg::result_t result_s2;
	logic              valid_s1, valid_s2;
	logic              advance, in_xfer;

	tmdg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held item moves on whenever the output register is free or is
	// being emptied in this same cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.mode           <= tmdg_pkg::mode_t'(s_axis_tuser);
			item_s1.button_pressed <= s_axis_tdata[0];
			item_s1.host_ready     <= s_axis_tdata[1];
			item_s1.read_ok        <= s_axis_tdata[2];
			item_s1.accel_x        <= signed'(s_axis_tdata[18:3]);
			item_s1.accel_y        <= signed'(s_axis_tdata[34:19]);
			item_s1.setup_ok       <= s_axis_tdata[35];
		end
	end

	// State is committed only when the item's result enters the output
	// register, so each item sees everything its predecessor left behind.
	tmdg_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000,
		result_s2.sensor_ready,
		result_s2.auto_mode,
		result_s2.delta_y,
		result_s2.delta_x,
		result_s2.report_valid};

endmodule
`default_nettype wire

@@ src/tmdg_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt mouse delta generator configuration registers
// Write-only register bank holding thresholds, limits and timing values.
// ----------------------------------------------------------------------------
module tmdg_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [tmdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tmdg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tmdg_pkg::cfg_t                         cfg
);

	tmdg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= tmdg_pkg::RST_DEBOUNCE_TICKS;
			cfg_q.tilt_low       <= tmdg_pkg::RST_TILT_LOW;
			cfg_q.tilt_mid       <= tmdg_pkg::RST_TILT_MID;
			cfg_q.tilt_high      <= tmdg_pkg::RST_TILT_HIGH;
			cfg_q.failure_limit  <= tmdg_pkg::RST_FAILURE_LIMIT;
			cfg_q.hold_reports   <= tmdg_pkg::RST_HOLD_REPORTS;
		end else if (cfg_wen) begin
			case (cfg_index)
				tmdg_pkg::REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[7:0];
				tmdg_pkg::REG_TILT_LOW:       cfg_q.tilt_low       <= cfg_data;
				tmdg_pkg::REG_TILT_MID:       cfg_q.tilt_mid       <= cfg_data;
				tmdg_pkg::REG_TILT_HIGH:      cfg_q.tilt_high      <= cfg_data;
				tmdg_pkg::REG_FAILURE_LIMIT:  cfg_q.failure_limit  <= cfg_data[3:0];
				tmdg_pkg::REG_HOLD_REPORTS:   cfg_q.hold_reports   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ src/tmdg_tilt_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt mouse delta generator threshold map
// Maps one signed tilt value to a movement of 0, +-2, +-5 or +-8.
// ----------------------------------------------------------------------------
module tmdg_tilt_map (
	input  wire logic signed [16:0] tilt,
	input  wire logic [14:0]        thr_low,
	input  wire logic [14:0]        thr_mid,
	input  wire logic [14:0]        thr_high,
	output logic signed [4:0]       delta
);

	logic signed [17:0] v;
	logic signed [17:0] lo, mid, hi;

	assign v   = {tilt[16], tilt};
	assign lo  = signed'({3'b000, thr_low});
	assign mid = signed'({3'b000, thr_mid});
	assign hi  = signed'({3'b000, thr_high});

	// Tested from the highest positive threshold down, then the negative ones.
	always_comb begin
		priority if (v > hi)   delta = 5'sd8;
		else if (v > mid)      delta = 5'sd5;
		else if (v > lo)       delta = 5'sd2;
		else if (v < -hi)      delta = -5'sd8;
		else if (v < -mid)     delta = -5'sd5;
		else if (v < -lo)      delta = -5'sd2;
		else                   delta = 5'sd0;
	end

endmodule
`default_nettype wire

@@ src/tmdg_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt mouse delta generator state update
// Holds the debounce, mode, sensor and circle state and forms one result
// from the current state and one item.
// ----------------------------------------------------------------------------
module tmdg_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire tmdg_pkg::item_t   item,
	input  wire tmdg_pkg::cfg_t    cfg,
	output tmdg_pkg::result_t      result
);

	logic       last_raw_q, deb_level_q, auto_q, ready_q;
	logic [7:0] stable_q, hold_q;
	logic [3:0] fail_q, step_q;

	logic       last_raw_n, deb_level_n, auto_n, ready_n;
	logic [7:0] stable_n, hold_n, hold_inc;
	logic [3:0] fail_n, step_n, step_cur, fail_inc;

	logic signed [16:0] tilt_x, tilt_y;
	logic signed [4:0]  map_x, map_y;
	tmdg_pkg::delta_t   circ;

	assign tilt_x = {item.accel_x[15], item.accel_x};
	assign tilt_y = -{item.accel_y[15], item.accel_y};

	tmdg_tilt_map u_map_x (
		.tilt     (tilt_x),
		.thr_low  (cfg.tilt_low),
		.thr_mid  (cfg.tilt_mid),
		.thr_high (cfg.tilt_high),
		.delta    (map_x)
	);

	tmdg_tilt_map u_map_y (
		.tilt     (tilt_y),
		.thr_low  (cfg.tilt_low),
		.thr_mid  (cfg.tilt_mid),
		.thr_high (cfg.tilt_high),
		.delta    (map_y)
	);

	assign step_cur = (step_q < 4'(tmdg_pkg::CIRCLE_LEN)) ? step_q : 4'd0;
	assign circ     = tmdg_pkg::circle_step_delta(step_cur);
	assign hold_inc = hold_q + 8'd1;
	assign fail_inc = (fail_q < cfg.failure_limit) ? fail_q + 4'd1 : fail_q;

	always_comb begin
		last_raw_n  = last_raw_q;
		deb_level_n = deb_level_q;
		auto_n      = auto_q;
		ready_n     = ready_q;
		stable_n    = stable_q;
		hold_n      = hold_q;
		fail_n      = fail_q;
		step_n      = step_q;
		result.report_valid = 1'b0;
		result.delta_x      = 5'sd0;
		result.delta_y      = 5'sd0;

		case (item.mode)
			tmdg_pkg::MODE_TICK: begin
				if (item.button_pressed != last_raw_q) begin
					last_raw_n = item.button_pressed;
					stable_n   = 8'd0;
				end else if (stable_q != 8'hFF) begin
					stable_n = stable_q + 8'd1;
				end
				if (stable_n >= cfg.debounce_ticks && item.button_pressed != deb_level_q) begin
					deb_level_n = item.button_pressed;
					if (item.button_pressed) begin
						auto_n = ~auto_q;
					end
				end
			end
			tmdg_pkg::MODE_REPORT: begin
				if (item.host_ready) begin
					result.report_valid = 1'b1;
					if (auto_q) begin
						result.delta_x = circ.dx;
						result.delta_y = circ.dy;
						if (hold_inc >= cfg.hold_reports) begin
							hold_n = 8'd0;
							step_n = (step_cur == 4'(tmdg_pkg::CIRCLE_LEN - 1)) ?
								4'd0 : step_cur + 4'd1;
						end else begin
							hold_n = hold_inc;
						end
					end else if (ready_q) begin
						if (item.read_ok) begin
							fail_n         = 4'd0;
							result.delta_x = map_x;
							result.delta_y = map_y;
						end else begin
							fail_n = fail_inc;
							if (fail_inc >= cfg.failure_limit) begin
								ready_n = 1'b0;
							end
						end
					end
				end
			end
			tmdg_pkg::MODE_SETUP: begin
				if (!ready_q && !auto_q) begin
					ready_n = item.setup_ok;
					if (item.setup_ok) begin
						fail_n = 4'd0;
					end
				end
			end
			default: ;
		endcase

		result.auto_mode    = auto_n;
		result.sensor_ready = ready_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b0;
			deb_level_q <= 1'b0;
			auto_q      <= 1'b0;
			ready_q     <= 1'b0;
			stable_q    <= 8'd0;
			hold_q      <= 8'd0;
			fail_q      <= 4'd0;
			step_q      <= 4'd0;
		end else if (fire) begin
			last_raw_q  <= last_raw_n;
			deb_level_q <= deb_level_n;
			auto_q      <= auto_n;
			ready_q     <= ready_n;
			stable_q    <= stable_n;
			hold_q      <= hold_n;
			fail_q      <= fail_n;
			step_q      <= step_n;
		end
	end

endmodule
`default_nettype wire
